FILE: rtl/lsb_first_bit_field_packer_unit_macros.svh
// Assertion macros for the LSB-first bit field packer.
// Included by the top level; no other dependencies.
`ifndef LSB_FIRST_BIT_FIELD_PACKER_UNIT_MACROS_SVH
`define LSB_FIRST_BIT_FIELD_PACKER_UNIT_MACROS_SVH
`ifndef SYNTH
`define LBP_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define LBP_ASSERT_NEXT(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) else $error(msg);
`else
`define LBP_ASSERT(lbl, ck, rn, prop, msg)
`define LBP_ASSERT_NEXT(lbl, ck, rn, pre, post, msg)
`endif
`endif

FILE: rtl/lsbp_pkg.sv
// Shared types and constants for the LSB-first bit field packer.
// No dependencies.
package lsbp_pkg;

	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 32;
	localparam int MODE_W  = 3;
	localparam int NBITS_W = 6;
	localparam int RES_CAP = 4;
	localparam int NUM_W   = 3;
	localparam int BUF_W   = VALUE_W + BYTE_W;

	localparam logic [MODE_W-1:0] MODE_UNSIGNED = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SIGNED   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BIT      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FLUSH    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

	// Bytes produced by one item, index 0 goes out first.
	typedef struct packed {
		logic [RES_CAP-1:0][BYTE_W-1:0] bytes;
		logic [NUM_W-1:0]               num;
		logic                           ovf;
	} batch_t;

endpackage

FILE: rtl/lsbp_core.sv
// Packing datapath and packer state: held byte, bit position, byte count, overflow.
// Depends on lsbp_pkg.
module lsbp_core #(
	parameter int MAX_FIELD_BITS = 32,
	parameter int COUNT_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [lsbp_pkg::MODE_W-1:0]         mode,
	input  logic [lsbp_pkg::VALUE_W-1:0]        value,
	input  logic [lsbp_pkg::NBITS_W-1:0]        bit_count,
	input  logic [15:0]                         limit,
	output lsbp_pkg::batch_t                    res,
	output logic                                res_any,
	output logic                                ovf_flag
);

	localparam int FW  = (MAX_FIELD_BITS > lsbp_pkg::VALUE_W) ? lsbp_pkg::VALUE_W
		: MAX_FIELD_BITS;
	localparam int CW  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int CP1 = COUNT_BITS + 1;

	function automatic logic [lsbp_pkg::VALUE_W-1:0] low_mask(
		input logic [lsbp_pkg::NBITS_W-1:0] n);
		logic [lsbp_pkg::VALUE_W:0] m;
		m = ~({(lsbp_pkg::VALUE_W+1){1'b1}} << n);
		return m[lsbp_pkg::VALUE_W-1:0];
	endfunction

	logic [7:0]            held_q;
	logic [3:0]            pos_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  ovf_q;

	logic [lsbp_pkg::NBITS_W-1:0] nf, nb, sum_m1, tot, newpos6;
	logic [lsbp_pkg::VALUE_W-1:0] fmask, maxmag, mag_raw, magc, w;
	logic                         neg, sgn, wr, fl;
	logic [lsbp_pkg::BUF_W-1:0]   bufw;
	logic [2:0]                   k, k_eff, avail, emit_n;
	logic [CW-1:0]                cnt_x, lim_x, room;
	logic                         over;
	logic [CP1-1:0]               sumc;
	logic [COUNT_BITS-1:0]        cnt_n;
	logic [7:0]                   newheld;

	always_comb begin
		nf      = (bit_count > lsbp_pkg::NBITS_W'(FW)) ? lsbp_pkg::NBITS_W'(FW) : bit_count;
		fmask   = low_mask(nf);
		maxmag  = low_mask(nf - 6'd1);
		neg     = value[lsbp_pkg::VALUE_W-1];
		mag_raw = neg ? (~value + 32'd1) : value;
		magc    = (mag_raw > maxmag) ? maxmag : mag_raw;
		sgn     = neg && (magc != '0);
		w       = '0;
		nb      = '0;
		case (mode)
			lsbp_pkg::MODE_UNSIGNED: begin
				// saturate to all ones when the value does not fit
				w  = ((value & ~fmask) != '0) ? fmask : value;
				nb = nf;
			end
			lsbp_pkg::MODE_SIGNED: begin
				// sign bit first, then magnitude
				w  = {magc[lsbp_pkg::VALUE_W-2:0], sgn};
				nb = nf;
			end
			lsbp_pkg::MODE_BIT: begin
				w  = {31'd0, value != '0};
				nb = 6'd1;
			end
			default: begin
				w  = '0;
				nb = '0;
			end
		endcase
		wr = !ovf_q && (nb != '0);
		fl = !ovf_q && (mode == lsbp_pkg::MODE_FLUSH);

		// held bits above pos_q are always zero
		bufw    = (lsbp_pkg::BUF_W'(w) << pos_q) | lsbp_pkg::BUF_W'(held_q);
		tot     = 6'(pos_q) + nb;
		sum_m1  = tot - 6'd1;
		k       = sum_m1[5:3];
		newpos6 = tot - {k, 3'b000};
		case (k)
			3'd0:    newheld = bufw[7:0];
			3'd1:    newheld = bufw[15:8];
			3'd2:    newheld = bufw[23:16];
			3'd3:    newheld = bufw[31:24];
			3'd4:    newheld = bufw[39:32];
			default: newheld = '0;
		endcase
		k_eff = wr ? k : (fl ? 3'd1 : 3'd0);

		cnt_x = CW'(cnt_q);
		lim_x = CW'(limit);
		room  = lim_x - cnt_x;
		if (cnt_x >= lim_x)
			avail = 3'd0;
		else if (room >= CW'(lsbp_pkg::RES_CAP))
			avail = 3'(lsbp_pkg::RES_CAP);
		else
			avail = room[2:0];
		over   = k_eff > avail;
		emit_n = over ? avail : k_eff;

		sumc  = CP1'(cnt_q) + CP1'(emit_n);
		cnt_n = sumc[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sumc[COUNT_BITS-1:0];
	end

	genvar gj;
	generate
		for (gj = 0; gj < lsbp_pkg::RES_CAP; gj++) begin : g_res
			assign res.bytes[gj] = (3'(gj) < emit_n) ? bufw[gj*8 +: 8] : 8'h00;
		end
	endgenerate

	assign res.num  = over ? (avail + 3'd1) : k_eff;
	assign res.ovf  = over;
	assign res_any  = res.num != '0;
	assign ovf_flag = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q  <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (step) begin
			if (mode == lsbp_pkg::MODE_CLEAR) begin
				held_q <= '0;
				pos_q  <= '0;
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
			end else if (over) begin
				held_q <= '0;
				pos_q  <= '0;
				cnt_q  <= cnt_n;
				ovf_q  <= 1'b1;
			end else if (wr) begin
				held_q <= newheld;
				pos_q  <= newpos6[3:0];
				cnt_q  <= cnt_n;
			end else if (fl) begin
				held_q <= '0;
				pos_q  <= '0;
				cnt_q  <= cnt_n;
			end
		end
	end

endmodule

FILE: rtl/lsbp_ser.sv
// Output serializer: holds one item's bytes and sends them one per transaction.
// Depends on lsbp_pkg.
module lsbp_ser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  lsbp_pkg::batch_t batch,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic             m_tuser
);

	logic [lsbp_pkg::RES_CAP-1:0][7:0] byte_q;
	logic [lsbp_pkg::NUM_W-1:0]        left_q;
	logic                              ovf_q;
	logic                              take;

	assign m_tvalid = left_q != '0;
	assign take     = m_tvalid && m_tready;
	assign m_tdata  = byte_q[0];
	assign m_tlast  = left_q == 3'd1;
	assign m_tuser  = m_tlast && ovf_q;
	assign free     = !m_tvalid || (take && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= batch.num;
		end else if (take) begin
			left_q <= left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= batch.bytes;
			ovf_q  <= batch.ovf;
		end else if (take) begin
			for (int i = 0; i < lsbp_pkg::RES_CAP - 1; i++)
				byte_q[i] <= byte_q[i+1];
			byte_q[lsbp_pkg::RES_CAP-1] <= '0;
		end
	end

endmodule

FILE: rtl/lsb_first_bit_field_packer_unit.sv
// Top level of the LSB-first bit field packer: input register, limit register,
// packing core and output serializer. Depends on lsbp_pkg, lsbp_core, lsbp_ser.
//
//   channel | direction | tdata / data              | tuser / side    | tlast
//   s_      | in        | [31:0] value,[37:32] count | [2:0] mode      | -
//   m_      | out       | [7:0] out_byte             | [0] overflowed  | last_of_item
//   cfg_    | in        | [15:0] byte_limit          | -               | -
//
// An accepted transaction waits in the input register, where the packing is
// done and the state updated; its bytes then leave at one per cycle while
// m_tready is high. Items that yield zero or one byte sustain one per cycle
// with m_tready high; larger items (up to four bytes) wait on the one-byte port.
// Reset clears the packer state, the byte count and the overflow flag; the
// byte limit comes up as 65535. Output stalls hold the input register only
// when its item has bytes to send and the serializer is still busy.
`include "lsb_first_bit_field_packer_unit_macros.svh"
module lsb_first_bit_field_packer_unit #(
	parameter int MAX_FIELD_BITS = 32,
	parameter int COUNT_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [37:32] bit_count, [39:38] zero
	input  logic [2:0]  s_tuser,   // [2:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic        m_tuser,   // [0] overflowed
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic                                valid_s1;
	logic [lsbp_pkg::MODE_W-1:0]         mode_s1;
	logic [lsbp_pkg::VALUE_W-1:0]        value_s1;
	logic [lsbp_pkg::NBITS_W-1:0]        nbits_s1;
	logic [15:0]                         limit_q;
	lsbp_pkg::batch_t                    res;
	logic                                res_any, ovf_flag, ser_free, advance, ser_load;

	// item leaves the input register when it yields nothing or the serializer frees up
	assign advance  = valid_s1 && (!res_any || ser_free);
	assign ser_load = advance && res_any;
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1  <= s_tuser;
			value_s1 <= s_tdata[31:0];
			nbits_s1 <= s_tdata[37:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	lsbp_core #(
		.MAX_FIELD_BITS (MAX_FIELD_BITS),
		.COUNT_BITS     (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.mode      (mode_s1),
		.value     (value_s1),
		.bit_count (nbits_s1),
		.limit     (limit_q),
		.res       (res),
		.res_any   (res_any),
		.ovf_flag  (ovf_flag)
	);

	lsbp_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ser_load),
		.batch    (res),
		.free     (ser_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	`LBP_ASSERT(a_load_when_free, clk, arst_n, ser_load |-> ser_free, "serializer overrun")
	`LBP_ASSERT(a_ovf_quiet, clk, arst_n, valid_s1 && ovf_flag && (mode_s1 != lsbp_pkg::MODE_CLEAR) |-> !res_any, "bytes after overflow")
	`LBP_ASSERT(a_ovf_is_last, clk, arst_n, m_tvalid && m_tuser |-> m_tlast, "overflow result not last")
	`LBP_ASSERT_NEXT(a_load_shows, clk, arst_n, ser_load, m_tvalid, "loaded batch not presented")

endmodule
